// File: rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int CNT_W    = 5;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_FIND   = 3'd3,
        OP_LENGTH = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic [2:0]               opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } ple_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         found_position;
        logic [CNT_W-1:0]         list_length;
    } ple_out_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [POS_W-1:0]         idx;
        logic signed [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

// File: rtl/ple_cell.sv
// One list cell: holds an entry, shifts from either neighbor, compares against the key.
module ple_cell import ple_pkg::*; (
    input  logic                     aclk,
    input  cell_cmd_t                cmd,
    input  logic [POS_W-1:0]         cell_idx,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] right_value,
    output logic signed [DATA_W-1:0] value,
    output logic                     is_match,
    output logic                     is_sel
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // Pick the next entry: hold, take the new item, or shift from a neighbor
    always_comb begin
        value_next = value_reg;
        if (cmd.ins) begin
            if (cell_idx == cmd.idx) begin
                value_next = cmd.data;
            end else if (cell_idx > cmd.idx) begin
                value_next = left_value;
            end
        end else if (cmd.del) begin
            if (cell_idx >= cmd.idx) begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    // Report key match and position select
    assign value    = value_reg;
    assign is_match = (value_reg == cmd.data);
    assign is_sel   = (cell_idx == cmd.idx);

endmodule

// File: rtl/positional_list_engine_unit.sv
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit entries held in a
// chain of cells, with insert, delete and read by 1-based position (0 acts as 1), find by
// value and a length query. Each request returns one result item carrying status, read
// value, found position and length after the request. A request is first registered; then,
// in the execute state, every cell shifts, loads or compares in parallel and the
// result register is loaded; the input side then reopens. The result register sits apart
// from the cells, so a new request is taken while an earlier result waits, and it stalls
// in the execute state only if that result has still not been taken.
module positional_list_engine_unit import ple_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ple_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ple_out_t m_data
);

    state_t           state_reg, state_next;
    ple_in_t          req_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    ple_out_t         m_data_reg, m_data_next;

    logic             exec_fire;
    logic [POS_W-1:0] pos_eff;
    logic             do_ins, do_del;
    cell_cmd_t        cmd;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]      cell_match;
    logic [CAPACITY-1:0]      cell_sel;
    logic [CAPACITY-1:0]      hit;
    logic                     any_hit;
    logic [POS_W-1:0]         first_idx;
    logic signed [DATA_W-1:0] rd_value;

    assign s_ready   = (state_reg == S_IDLE);
    assign exec_fire = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign pos_eff   = (req_reg.position == '0) ? POS_W'(1) : req_reg.position;

    // Broadcast the command; only a firing request may move the cells
    always_comb begin
        cmd.ins  = exec_fire && do_ins;
        cmd.del  = exec_fire && do_del;
        cmd.idx  = pos_eff - POS_W'(1);
        cmd.data = req_reg.item_value;
    end

    // Build the cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [DATA_W-1:0] left_v, right_v;
            if (gi == 0) begin : g_first
                assign left_v = '0;
            end else begin : g_mid_l
                assign left_v = cell_value[gi-1];
            end
            if (gi == CAPACITY-1) begin : g_last
                assign right_v = cell_value[gi];
            end else begin : g_mid_r
                assign right_v = cell_value[gi+1];
            end
            ple_cell u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .cell_idx    (POS_W'(gi)),
                .left_value  (left_v),
                .right_value (right_v),
                .value       (cell_value[gi]),
                .is_match    (cell_match[gi]),
                .is_sel      (cell_sel[gi])
            );
        end
    endgenerate

    // Mask matches to live entries, pick the first, and gather the selected entry
    always_comb begin
        any_hit   = 1'b0;
        first_idx = '0;
        rd_value  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit[i] = cell_match[i] && (CNT_W'(i) < count_reg);
            if (cell_sel[i]) begin
                rd_value = rd_value | cell_value[i];
            end
        end
        for (int i = CAPACITY-1; i >= 0; i--) begin
            if (hit[i]) begin
                any_hit   = 1'b1;
                first_idx = POS_W'(i);
            end
        end
    end

    // Decide status, cell action and result fields
    always_comb begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        count_next  = count_reg;
        m_data_next = m_data_reg;
        m_data_next.status         = ST_OK;
        m_data_next.read_value     = '0;
        m_data_next.found_position = '0;
        case (req_reg.opcode)
            OP_INSERT: begin
                if ({1'b0, pos_eff} > ({1'b0, count_reg} + (CNT_W+1)'(1))) begin
                    m_data_next.status = ST_BADPOS;
                end else if (count_reg == CNT_W'(CAPACITY)) begin
                    m_data_next.status = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (count_reg == '0 || pos_eff > count_reg) begin
                    m_data_next.status = ST_BADPOS;
                end else begin
                    do_del     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (count_reg == '0 || pos_eff > count_reg) begin
                    m_data_next.status = ST_BADPOS;
                end else begin
                    m_data_next.read_value = rd_value;
                end
            end
            OP_FIND: begin
                if (count_reg == '0) begin
                    m_data_next.status = ST_BADPOS;
                end else if (any_hit) begin
                    m_data_next.found_position = first_idx + POS_W'(1);
                end else begin
                    m_data_next.status = ST_NOTFOUND;
                end
            end
            OP_LENGTH: begin
                m_data_next.status = ST_OK;
            end
            default: begin
                m_data_next.status = ST_BADPOS;
            end
        endcase
        m_data_next.list_length = count_next;
    end

    // Advance the request sequencer and the result handshake
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_fire) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (exec_fire) begin
                count_reg <= count_next;
            end
        end
    end

    // Payload registers: hold the request and the result
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (exec_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
